// ===== src/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg: swing peak detector shared definitions
// Field widths, register reset values, register codes and the default
// sample width used by the swing peak detector.
// ----------------------------------------------------------------------------
package spd_pkg;

   // field widths fixed by the interface
   localparam int ACCEL_W    = 16;
   localparam int TIME_W     = 32;
   localparam int SWING_W    = 32;
   localparam int PEAK_OUT_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int MAG_SQ_W   = 32;

   // threshold squarer runs one bit of the threshold per cycle
   localparam int THR_W     = 16;
   localparam int HOLD_W    = 16;
   localparam int THR_CNT_W = $clog2(THR_W + 1);

   // default sample width
   localparam int SAMPLE_BITS_DEFAULT = 16;

   typedef logic [MAG_SQ_W-1:0]   mag_sq_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [SWING_W-1:0]    swing_type;
   typedef logic [PEAK_OUT_W-1:0] peak_out_type;
   typedef logic [THR_W-1:0]      thr_type;
   typedef logic [HOLD_W-1:0]     hold_type;
   typedef logic [THR_CNT_W-1:0]  thr_cnt_type;

   // register reset values: 1.5 g threshold, 40 ms hold-off
   localparam thr_type    THR_RESET    = thr_type'(3072);
   localparam hold_type   HOLD_RESET   = hold_type'(40);
   localparam mag_sq_type THR_SQ_RESET = mag_sq_type'(3072 * 3072);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_HOLDOFF   = 1'b1
   } csr_index_type;

endpackage

// ===== src/spd_isqrt.sv =====
// ----------------------------------------------------------------------------
// spd_isqrt: digit-serial integer square root
// Restoring square root, two radicand bits in and one root bit out per
// cycle. Gives floor(sqrt(value)) and raises done when the root is ready.
// ----------------------------------------------------------------------------
module spd_isqrt #(
   parameter int ROOT_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   value,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);

   localparam int VAL_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int WRK_W = REM_W + 2;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [VAL_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [WRK_W-1:0]  rem_sh;
   logic [WRK_W-1:0]  trial;
   logic [WRK_W-1:0]  diff;
   logic              fit;

   // one root digit per cycle
   always_comb begin
      rem_sh = {rem_ff, val_ff[VAL_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      diff   = rem_sh - trial;
      fit    = (rem_sh >= trial);

      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;

      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         val_in  = {val_ff[VAL_W-3:0], 2'b00};
         rem_in  = fit ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fit};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== src/swing_peak_detector.sv =====
// ----------------------------------------------------------------------------
// swing_peak_detector: threshold peak detector with hold-off
// Squares each accelerometer sample bit-serially, compares the squared
// magnitude with the squared threshold, tracks the swing peak and reports
// the swing number and the root of the peak once the hold-off has passed.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             word
//   req_     in         req_valid/req_stall   accel_x, accel_y, accel_z, time_ms
//   rsp_     out        rsp_valid/rsp_stall   swing_number, peak_counts
//   csr_     in         csr_write             csr_index, csr_data
//
// a sample passes the bit-serial squarer in the square state, then the
// decide state
// a sample that ends a swing then passes the root state, where the
// digit-serial square root runs, and the done state
// a threshold write holds req_stall high while the threshold is squared
// a finished word waits in the output register; the next sample is taken
// meanwhile, and rsp_stall holds the word in place
// reset is synchronous and leaves the registers at 1.5 g and 40 ms
// ----------------------------------------------------------------------------
module swing_peak_detector #(
   parameter int SAMPLE_BITS = spd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [spd_pkg::ACCEL_W-1:0] req_accel_x,
   input  logic signed [spd_pkg::ACCEL_W-1:0] req_accel_y,
   input  logic signed [spd_pkg::ACCEL_W-1:0] req_accel_z,
   input  logic [spd_pkg::TIME_W-1:0]        req_time_ms,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [spd_pkg::SWING_W-1:0]       rsp_swing_number,
   output logic [spd_pkg::PEAK_OUT_W-1:0]    rsp_peak_counts,

   input  logic                              csr_write,
   input  logic [spd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int PEAK_W = 2 * SAMPLE_BITS;
   localparam int CNT_W  = $clog2(SAMPLE_BITS + 1);
   localparam int LANES  = 3;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [PEAK_W-1:0]      peak_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DECIDE,
      ST_ROOT,
      ST_DONE
   } state_type;

   // configuration
   spd_pkg::thr_type     thr_ff, thr_in;
   spd_pkg::thr_type     thr_sh_ff, thr_sh_in;
   spd_pkg::mag_sq_type  thr_sq_ff, thr_sq_in;
   spd_pkg::thr_cnt_type thr_cnt_ff, thr_cnt_in;
   spd_pkg::hold_type    hold_ff, hold_in;

   // sample squarer
   sample_type           mc_ff [LANES];
   sample_type           mc_in [LANES];
   sample_type           sh_ff [LANES];
   sample_type           sh_in [LANES];
   sample_type           raw   [LANES];
   sample_type           mag   [LANES];
   peak_type             acc_ff, acc_in;
   logic [CNT_W-1:0]     sq_cnt_ff, sq_cnt_in;
   spd_pkg::time_type    time_ff, time_in;

   // swing state
   state_type            state_ff, state_in;
   logic                 in_swing_ff, in_swing_in;
   peak_type             peak_ff, peak_in;
   spd_pkg::time_type    last_above_ff, last_above_in;
   spd_pkg::swing_type   total_ff, total_in;
   spd_pkg::swing_type   pend_swing_ff, pend_swing_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   spd_pkg::swing_type   rsp_swing_ff, rsp_swing_in;
   spd_pkg::peak_out_type rsp_peak_ff, rsp_peak_in;

   // decision terms
   spd_pkg::mag_sq_type  mag_sq;
   spd_pkg::time_type    gap;
   logic                 above;
   logic                 starting;
   logic                 swing_mid;
   logic                 end_hit;
   peak_type             peak_mid;
   spd_pkg::swing_type   total_mid;

   logic                 req_accept;
   logic                 out_free;
   logic                 root_start;
   logic                 root_done;
   sample_type           root_value;

   assign req_stall  = (state_ff != ST_IDLE) || (thr_cnt_ff != '0);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // low sample bits of each axis
   assign raw[0] = req_accel_x[SAMPLE_BITS-1:0];
   assign raw[1] = req_accel_y[SAMPLE_BITS-1:0];
   assign raw[2] = req_accel_z[SAMPLE_BITS-1:0];

   // configuration writes and the bit-serial threshold squarer
   always_comb begin
      thr_in     = thr_ff;
      hold_in    = hold_ff;
      thr_sh_in  = thr_sh_ff;
      thr_sq_in  = thr_sq_ff;
      thr_cnt_in = thr_cnt_ff;

      if (thr_cnt_ff != '0) begin
         thr_sq_in  = {thr_sq_ff[spd_pkg::MAG_SQ_W-2:0], 1'b0}
                    + (thr_sh_ff[spd_pkg::THR_W-1] ? spd_pkg::mag_sq_type'(thr_ff) : '0);
         thr_sh_in  = {thr_sh_ff[spd_pkg::THR_W-2:0], 1'b0};
         thr_cnt_in = thr_cnt_ff - 1'b1;
      end

      if (csr_write) begin
         case (spd_pkg::csr_index_type'(csr_index))
            spd_pkg::CSR_THRESHOLD: begin
               thr_in     = spd_pkg::thr_type'(csr_data);
               thr_sh_in  = spd_pkg::thr_type'(csr_data);
               thr_sq_in  = '0;
               thr_cnt_in = spd_pkg::thr_cnt_type'(spd_pkg::THR_W);
            end
            spd_pkg::CSR_HOLDOFF: begin
               hold_in = spd_pkg::hold_type'(csr_data);
            end
            default: begin
               hold_in = hold_ff;
            end
         endcase
      end
   end

   // magnitude of each axis, then one multiplier bit per cycle
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         mag[i]   = raw[i][SAMPLE_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
         mc_in[i] = mc_ff[i];
         sh_in[i] = sh_ff[i];
      end
      acc_in    = acc_ff;
      sq_cnt_in = sq_cnt_ff;
      time_in   = time_ff;

      if (req_accept) begin
         for (int i = 0; i < LANES; i++) begin
            mc_in[i] = mag[i];
            sh_in[i] = mag[i];
         end
         acc_in    = '0;
         sq_cnt_in = CNT_W'(SAMPLE_BITS);
         time_in   = req_time_ms;
      end else if (sq_cnt_ff != '0) begin
         acc_in = {acc_ff[PEAK_W-2:0], 1'b0}
                + (sh_ff[0][SAMPLE_BITS-1] ? peak_type'(mc_ff[0]) : '0)
                + (sh_ff[1][SAMPLE_BITS-1] ? peak_type'(mc_ff[1]) : '0)
                + (sh_ff[2][SAMPLE_BITS-1] ? peak_type'(mc_ff[2]) : '0);
         for (int i = 0; i < LANES; i++) begin
            sh_in[i] = {sh_ff[i][SAMPLE_BITS-2:0], 1'b0};
         end
         sq_cnt_in = sq_cnt_ff - 1'b1;
      end
   end

   // threshold compare, peak update and hold-off check
   always_comb begin
      mag_sq    = spd_pkg::mag_sq_type'(acc_ff);
      above     = (mag_sq >= thr_sq_ff);
      starting  = above && !in_swing_ff;
      swing_mid = in_swing_ff || above;
      total_mid = starting ? (total_ff + 1'b1) : total_ff;
      if (starting || (above && (acc_ff > peak_ff))) begin
         peak_mid = acc_ff;
      end else begin
         peak_mid = peak_ff;
      end
      gap     = time_ff - last_above_ff;
      end_hit = swing_mid && (above ? (hold_ff == '0)
                                    : (gap >= spd_pkg::time_type'(hold_ff)));
   end

   assign root_start = (state_ff == ST_DECIDE) && end_hit;

   // sequencer and swing state
   always_comb begin
      state_in      = state_ff;
      in_swing_in   = in_swing_ff;
      peak_in       = peak_ff;
      last_above_in = last_above_ff;
      total_in      = total_ff;
      pend_swing_in = pend_swing_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_swing_in  = rsp_swing_ff;
      rsp_peak_in   = rsp_peak_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_cnt_ff == CNT_W'(1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            total_in = total_mid;
            if (above) begin
               last_above_in = time_ff;
            end
            if (end_hit) begin
               in_swing_in   = 1'b0;
               peak_in       = '0;
               pend_swing_in = total_mid;
               state_in      = ST_ROOT;
            end else begin
               in_swing_in = swing_mid;
               peak_in     = peak_mid;
               state_in    = ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_swing_in = pend_swing_ff;
               rsp_peak_in  = spd_pkg::peak_out_type'(root_value);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         mc_ff[i] <= mc_in[i];
         sh_ff[i] <= sh_in[i];
      end
      acc_ff        <= acc_in;
      time_ff       <= time_in;
      thr_sh_ff     <= thr_sh_in;
      pend_swing_ff <= pend_swing_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= spd_pkg::THR_RESET;
         hold_ff    <= spd_pkg::HOLD_RESET;
         thr_sq_ff  <= spd_pkg::THR_SQ_RESET;
         thr_cnt_ff <= '0;
      end else begin
         thr_ff     <= thr_in;
         hold_ff    <= hold_in;
         thr_sq_ff  <= thr_sq_in;
         thr_cnt_ff <= thr_cnt_in;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sq_cnt_ff     <= '0;
         in_swing_ff   <= 1'b0;
         peak_ff       <= '0;
         last_above_ff <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sq_cnt_ff     <= sq_cnt_in;
         in_swing_ff   <= in_swing_in;
         peak_ff       <= peak_in;
         last_above_ff <= last_above_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_swing_ff <= rsp_swing_in;
      rsp_peak_ff  <= rsp_peak_in;
   end

   // square root of the swing peak
   spd_isqrt #(
      .ROOT_W (SAMPLE_BITS)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (peak_mid),
      .done  (root_done),
      .root  (root_value)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_swing_number = rsp_swing_ff;
   assign rsp_peak_counts  = rsp_peak_ff;

   // squarer runs exactly while in the square state
   a_square_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) == (sq_cnt_ff != '0))
      else $error("squarer count out of step with sequencer");

   // root finishes only while the sequencer waits for it
   a_root_done: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_ROOT))
      else $error("square root finished outside root state");

   // a new word comes only from the done state
   a_word_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word loaded outside done state");

   // a reported swing has been closed and its peak cleared
   a_swing_closed: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (!in_swing_ff && (peak_ff == '0)))
      else $error("swing still open when its word is reported");

   // no sample is taken while the threshold square is being formed
   a_thr_busy: assert property (@(posedge clock) disable iff (reset)
      (thr_cnt_ff != '0) |-> (state_ff == ST_IDLE) || (state_ff == ST_DONE)
                             || $past(csr_write))
      else $error("sample in flight while threshold square is rebuilt");

endmodule

// ===== tb/swing_peak_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swing_peak_detector_test: self-checking bench for the swing peak detector
// Walks a short table of hand-picked samples and register writes, then runs
// several random phases under different threshold and hold-off settings.
// Every accepted sample goes through a local model of the detector and each
// reported word is compared with the oldest predicted swing report.
// ----------------------------------------------------------------------------
module swing_peak_detector_test;

   localparam int RUN_LIMIT  = 1_000_000;
   localparam int DRAIN_WAIT = 40;
   localparam int THR_MAX    = 56756;

   typedef logic signed [spd_pkg::ACCEL_W-1:0] accel_type;

   typedef struct {
      spd_pkg::swing_type    swing_no;
      spd_pkg::peak_out_type peak;
   } swing_report_type;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      spd_pkg::csr_index_type         reg_sel;
      logic [spd_pkg::CSR_DATA_W-1:0] reg_value;
      accel_type                      ax, ay, az;
      spd_pkg::time_type              stamp;
      bit                             typed;    // expected outcome written in the row
      bit                             fires;
      swing_report_type               report;
   } stim_row_type;

   // block ports
   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           req_valid       = 1'b0;
   logic                           req_stall;
   accel_type                      req_accel_x     = '0;
   accel_type                      req_accel_y     = '0;
   accel_type                      req_accel_z     = '0;
   spd_pkg::time_type              req_time_ms     = '0;
   logic                           rsp_valid;
   logic                           rsp_stall       = 1'b0;
   spd_pkg::swing_type             rsp_swing_number;
   spd_pkg::peak_out_type          rsp_peak_counts;
   logic                           csr_write       = 1'b0;
   logic [spd_pkg::CSR_IDX_W-1:0]  csr_index       = '0;
   logic [spd_pkg::CSR_DATA_W-1:0] csr_data        = '0;

   // detector model state and its register copies
   spd_pkg::thr_type    cfg_threshold;
   spd_pkg::hold_type   cfg_holdoff;
   bit                  swing_open;
   spd_pkg::mag_sq_type peak_square;
   spd_pkg::time_type   last_loud_ms;
   spd_pkg::swing_type  swings_seen;

   swing_report_type pending_reports[$];
   swing_report_type oldest_report;
   stim_row_type     opening_rows[$];

   int fail_count  = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_left  = 0;
   int stall_mode;

   swing_peak_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_swing_number (rsp_swing_number),
      .rsp_peak_counts  (rsp_peak_counts),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // floor square root, one root bit per pass
   function automatic spd_pkg::peak_out_type floor_root(input spd_pkg::mag_sq_type value);
      spd_pkg::peak_out_type root;
      spd_pkg::peak_out_type trial;
      root = '0;
      for (int b = spd_pkg::PEAK_OUT_W - 1; b >= 0; b--) begin
         trial = root | (spd_pkg::peak_out_type'(1) << b);
         if (64'(trial) * 64'(trial) <= 64'(value))
            root = trial;
      end
      return root;
   endfunction

   // advance the detector model by one sample; returns 1 when a swing ends
   function automatic bit predict_swing_end(input accel_type ax, ay, az,
                                            input spd_pkg::time_type now,
                                            output swing_report_type report);
      longint              sx, sy, sz;
      spd_pkg::mag_sq_type mag_sq;
      logic [63:0]         thr_sq;
      spd_pkg::time_type   elapsed;
      sx = ax;
      sy = ay;
      sz = az;
      mag_sq = spd_pkg::mag_sq_type'(sx * sx + sy * sy + sz * sz);
      thr_sq = 64'(cfg_threshold) * 64'(cfg_threshold);
      report.swing_no = '0;
      report.peak = '0;

      // at or above threshold: open or extend the swing
      if (64'(mag_sq) >= thr_sq) begin
         if (!swing_open) begin
            swing_open = 1'b1;
            peak_square = mag_sq;
            swings_seen = swings_seen + 1'b1;
         end else if (mag_sq > peak_square) begin
            peak_square = mag_sq;
         end
         last_loud_ms = now;
      end

      // hold-off elapsed: close the swing and report it
      elapsed = now - last_loud_ms;
      if (swing_open && elapsed >= spd_pkg::time_type'(cfg_holdoff)) begin
         report.swing_no = swings_seen;
         report.peak = floor_root(peak_square);
         swing_open = 1'b0;
         peak_square = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void add_sample(input accel_type ax, ay, az,
                                      input spd_pkg::time_type stamp,
                                      input bit typed = 1'b0, input bit fires = 1'b0,
                                      input spd_pkg::swing_type swing_no = '0,
                                      input spd_pkg::peak_out_type peak = '0);
      stim_row_type row;
      row.kind = ROW_SAMPLE;
      row.reg_sel = spd_pkg::CSR_THRESHOLD;
      row.reg_value = '0;
      row.ax = ax;
      row.ay = ay;
      row.az = az;
      row.stamp = stamp;
      row.typed = typed;
      row.fires = fires;
      row.report.swing_no = swing_no;
      row.report.peak = peak;
      opening_rows.push_back(row);
   endfunction

   function automatic void add_write(input spd_pkg::csr_index_type sel,
                                     input logic [spd_pkg::CSR_DATA_W-1:0] value);
      stim_row_type row;
      row.kind = ROW_WRITE;
      row.reg_sel = sel;
      row.reg_value = value;
      row.ax = '0;
      row.ay = '0;
      row.az = '0;
      row.stamp = '0;
      row.typed = 1'b0;
      row.fires = 1'b0;
      row.report.swing_no = '0;
      row.report.peak = '0;
      opening_rows.push_back(row);
   endfunction

   // one sample word through the input handshake, sender paced in bursts
   task automatic send_sample(input accel_type ax, ay, az, input spd_pkg::time_type stamp);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 24)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_time_ms <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // register write once the block has drained
   task automatic retune(input spd_pkg::csr_index_type sel,
                         input logic [spd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (sel == spd_pkg::CSR_THRESHOLD)
         cfg_threshold = value;
      else
         cfg_holdoff = value;
   endtask

   // receiver stall pattern: free runs, stall runs and coin flips
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_mode = $urandom_range(0, 9);
         if (stall_mode < 4) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 60);
         end else if (stall_mode < 7) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
         end else begin
            rsp_stall  <= 1'($urandom_range(0, 1));
            stall_left <= 0;
         end
      end
   end

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected word: swing_number %0d peak_counts %0d",
                   rsp_swing_number, rsp_peak_counts);
            fail_count++;
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_swing_number !== oldest_report.swing_no) begin
               $error("swing_number: expected %0d, actual %0d",
                      oldest_report.swing_no, rsp_swing_number);
               fail_count++;
            end
            if (rsp_peak_counts !== oldest_report.peak) begin
               $error("peak_counts: expected %0d, actual %0d",
                      oldest_report.peak, rsp_peak_counts);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("swing_peak_detector_test failed");
         $finish;
      end
   end

   initial begin
      stim_row_type      row;
      swing_report_type  report;
      bit                fired;
      accel_type         ax, ay, az;
      spd_pkg::time_type ms_cursor;
      int                new_thr, new_hold, items;
      int                thr, hold, pick, mag, spread, loud_min, rot;
      int                loud_left;
      int                axis_val[3];

      cfg_threshold = spd_pkg::THR_RESET;
      cfg_holdoff   = spd_pkg::HOLD_RESET;
      swing_open    = 1'b0;
      peak_square   = '0;
      last_loud_ms  = '0;
      swings_seen   = '0;
      loud_left     = 0;

      // opening table, reset settings of 1.5 g and 40 ms first
      add_sample(0, 0, 0, 0, 1, 0);
      add_sample(3072, 0, 0, 10, 1, 0);                   // exactly at threshold
      add_sample(-32768, -32768, -32768, 20, 1, 0);       // largest magnitude
      add_sample(32767, 32767, 32767, 30, 1, 0);
      add_sample(0, 0, 0, 69, 1, 0);                      // one short of hold-off
      add_sample(0, 0, 0, 70, 1, 1, 1, 56755);
      add_sample(3071, 0, 0, 80, 1, 0);                   // just below threshold
      add_sample(0, -3072, 0, 100, 1, 0);
      add_sample(0, 0, 0, 50, 1, 1, 2, 3072);             // time steps backwards
      add_sample(0, 0, 3072, 32'hFFFF_FFF0, 1, 0);
      add_sample(1200, -2500, 1800, 32'h0000_0017);       // timestamp wrapped
      add_sample(0, 0, 0, 32'h0000_003F);
      add_sample(2047, -2048, 2047, 200);
      add_sample(-1, 1, -1, 240);
      // zero hold-off: swing opens and closes on one sample
      add_write(spd_pkg::CSR_HOLDOFF, 0);
      add_sample(3072, 0, 0, 300, 1, 1, 5, 3072);
      add_sample(100, 0, 0, 301, 1, 0);
      // zero threshold: every sample is loud
      add_write(spd_pkg::CSR_THRESHOLD, 0);
      add_sample(0, 0, 0, 302, 1, 1, 6, 0);
      add_write(spd_pkg::CSR_HOLDOFF, 16'hFFFF);
      add_sample(0, 0, 0, 1000, 1, 0);
      add_sample(-32768, 0, 0, 2000, 1, 0);
      add_write(spd_pkg::CSR_THRESHOLD, 3072);
      add_sample(5, 5, 5, 2000 + 65534, 1, 0);
      add_sample(5, 5, 5, 2000 + 65535, 1, 1, 7, 32768);
      // largest threshold: nothing reaches it
      add_write(spd_pkg::CSR_THRESHOLD, spd_pkg::CSR_DATA_W'(THR_MAX));
      add_sample(-32768, -32768, -32768, 70000, 1, 0);
      add_sample(32767, -32768, 32767, 70001, 1, 0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the opening table
      foreach (opening_rows[i]) begin
         row = opening_rows[i];
         if (row.kind == ROW_WRITE) begin
            retune(row.reg_sel, row.reg_value);
         end else begin
            send_sample(row.ax, row.ay, row.az, row.stamp);
            fired = predict_swing_end(row.ax, row.ay, row.az, row.stamp, report);
            if (row.typed) begin
               fired = row.fires;
               report = row.report;
            end
            if (fired)
               pending_reports.push_back(report);
         end
      end

      // random phases, each under its own register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin new_thr = 3072; new_hold = 40; items = 300; end
            1: begin
               new_thr = $urandom_range(0, 32767);
               new_hold = $urandom_range(1, 60);
               items = 240;
            end
            2: begin new_thr = 0; new_hold = $urandom_range(10, 40); items = 120; end
            3: begin new_thr = $urandom_range(500, 6000); new_hold = 0; items = 200; end
            4: begin new_thr = THR_MAX; new_hold = 65535; items = 60; end
            5: begin
               new_thr = $urandom_range(40000, THR_MAX);
               new_hold = $urandom_range(0, 65535);
               items = 160;
            end
            6: begin new_thr = $urandom_range(0, THR_MAX); new_hold = 65535; items = 120; end
            default: begin
               new_thr = $urandom_range(1000, 20000);
               new_hold = $urandom_range(5, 200);
               items = 250;
            end
         endcase
         retune(spd_pkg::CSR_THRESHOLD, spd_pkg::CSR_DATA_W'(new_thr));
         retune(spd_pkg::CSR_HOLDOFF, spd_pkg::CSR_DATA_W'(new_hold));
         ms_cursor = $urandom();

         repeat (items) begin
            thr  = int'(cfg_threshold);
            hold = int'(cfg_holdoff);
            pick = $urandom_range(0, 99);

            // sample: raw noise, loud burst or quiet stretch
            if (pick < 10) begin
               axis_val[0] = $urandom_range(0, 65535);
               axis_val[1] = $urandom_range(0, 65535);
               axis_val[2] = $urandom_range(0, 65535);
            end else if (loud_left > 0) begin
               loud_left--;
               if (thr <= 32767) begin
                  mag = ($urandom_range(0, 9) < 2) ? thr : $urandom_range(thr, 32767);
                  spread = thr / 2;
                  axis_val[0] = $urandom_range(0, 1) ? -mag : mag;
                  axis_val[1] = $urandom_range(0, 2 * spread) - spread;
                  axis_val[2] = $urandom_range(0, 2 * spread) - spread;
               end else begin
                  loud_min = (thr * 58) / 100;
                  if (loud_min > 32767)
                     loud_min = 32767;
                  for (int k = 0; k < 3; k++) begin
                     mag = $urandom_range(loud_min, 32767);
                     axis_val[k] = $urandom_range(0, 1) ? -mag : mag;
                  end
               end
            end else begin
               if (thr > 0 && thr <= 32768 && $urandom_range(0, 6) == 0) begin
                  axis_val[0] = $urandom_range(0, 1) ? -(thr - 1) : thr - 1;
                  axis_val[1] = 0;
                  axis_val[2] = 0;
               end else begin
                  spread = (thr * 57) / 100;
                  for (int k = 0; k < 3; k++)
                     axis_val[k] = $urandom_range(0, 2 * spread) - spread;
               end
               if ($urandom_range(0, 9) == 0)
                  loud_left = $urandom_range(1, 8);
            end
            rot = $urandom_range(0, 2);
            ax = accel_type'(axis_val[rot]);
            ay = accel_type'(axis_val[(rot + 1) % 3]);
            az = accel_type'(axis_val[(rot + 2) % 3]);

            // timestamp: small steps, hold-off sized gaps, the boundary, or a jump
            pick = $urandom_range(0, 99);
            if (pick < 70)
               ms_cursor = ms_cursor + $urandom_range(0, 12);
            else if (pick < 85)
               ms_cursor = ms_cursor + $urandom_range(0, hold + hold / 8 + 2);
            else if (pick < 95 && swing_open)
               ms_cursor = last_loud_ms + hold - 1 + $urandom_range(0, 2);
            else
               ms_cursor = $urandom();

            send_sample(ax, ay, az, ms_cursor);
            if (predict_swing_end(ax, ay, az, ms_cursor, report))
               pending_reports.push_back(report);
         end
      end

      // drain and settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("swing_peak_detector_test passed");
      else
         $display("swing_peak_detector_test failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/spd_pkg.sv
src/spd_isqrt.sv
src/swing_peak_detector.sv
tb/swing_peak_detector_test.sv
